FILE: src/chacha20_keystream_block_top_macros.svh
// Assertion macros shared by the keystream block RTL.
`ifndef CHACHA20_KEYSTREAM_BLOCK_TOP_MACROS_SVH
`define CHACHA20_KEYSTREAM_BLOCK_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CC20_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CC20_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/cc20_pkg.sv
// Types, constants and quarter-round step functions of the ChaCha20 keystream block.
package cc20_pkg;

   localparam int unsigned WORD_W       = 32;
   localparam int unsigned FIELD_W      = 64;
   localparam int unsigned COUNTER_W    = 32;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned NUM_WORDS    = 16;
   localparam int unsigned NUM_FIELDS   = 8;
   localparam int unsigned NUM_KEY_REGS = 4;
   localparam int unsigned ROUND_COUNT_DEFAULT = 20;

   localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
   localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
   localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
   localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

   typedef logic [NUM_WORDS-1:0][WORD_W-1:0]  word_array_type;
   typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] field_array_type;
   typedef logic [NUM_KEY_REGS-1:0][FIELD_W-1:0] key_array_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_01   = 3'd0,
      CSR_KEY_23   = 3'd1,
      CSR_KEY_45   = 3'd2,
      CSR_KEY_67   = 3'd3,
      CSR_NONCE_01 = 3'd4,
      CSR_NONCE_2  = 3'd5
   } csr_index_type;

   // Quarter-round step codes: each applies one add, one xor and one rotate.
   typedef enum logic [1:0] {
      STEP_A_ROT16 = 2'd0,
      STEP_C_ROT12 = 2'd1,
      STEP_A_ROT8  = 2'd2,
      STEP_C_ROT7  = 2'd3
   } step_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   // Builds the sixteen-word input state of one block.
   function automatic word_array_type init_state(input key_array_type key,
                                                 input logic [FIELD_W-1:0] nonce01,
                                                 input logic [WORD_W-1:0] nonce2,
                                                 input logic [COUNTER_W-1:0] counter);
      word_array_type s;
      s[0] = SIGMA0;
      s[1] = SIGMA1;
      s[2] = SIGMA2;
      s[3] = SIGMA3;
      for (int i = 0; i < NUM_KEY_REGS; i++) begin
         s[4 + 2 * i] = key[i][WORD_W-1:0];
         s[5 + 2 * i] = key[i][FIELD_W-1:WORD_W];
      end
      s[12] = counter;
      s[13] = nonce01[WORD_W-1:0];
      s[14] = nonce01[FIELD_W-1:WORD_W];
      s[15] = nonce2;
      return s;
   endfunction

   // One quarter-round step applied to all four quarter rounds of a column
   // or diagonal round; the four quarter rounds touch disjoint words.
   function automatic word_array_type qr_step(input word_array_type s,
                                              input step_type step,
                                              input logic diag);
      word_array_type r;
      logic [1:0] jj;
      logic [3:0] ia, ib, ic, id;
      r = s;
      for (int j = 0; j < 4; j++) begin
         jj = 2'(j);
         ia = {2'b00, jj};
         ib = {2'b01, jj + (diag ? 2'd1 : 2'd0)};
         ic = {2'b10, jj + (diag ? 2'd2 : 2'd0)};
         id = {2'b11, jj + (diag ? 2'd3 : 2'd0)};
         unique case (step)
            STEP_A_ROT16: begin
               r[ia] = s[ia] + s[ib];
               r[id] = rotl(s[id] ^ r[ia], 16);
            end
            STEP_C_ROT12: begin
               r[ic] = s[ic] + s[id];
               r[ib] = rotl(s[ib] ^ r[ic], 12);
            end
            STEP_A_ROT8: begin
               r[ia] = s[ia] + s[ib];
               r[id] = rotl(s[id] ^ r[ia], 8);
            end
            STEP_C_ROT7: begin
               r[ic] = s[ic] + s[id];
               r[ib] = rotl(s[ib] ^ r[ic], 7);
            end
            default: r = s;
         endcase
      end
      return r;
   endfunction

endpackage

FILE: src/cc20_if.sv
// Channel interfaces of the keystream block: counter input, keystream output, register writes.
interface cc20_req_if
   import cc20_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [COUNTER_W-1:0] block_counter;

   modport source (output valid, output block_counter, input ready);
   modport sink   (input valid, input block_counter, output ready);
endinterface

interface cc20_rsp_if
   import cc20_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] stream_bytes_0_7;
   logic [FIELD_W-1:0] stream_bytes_8_15;
   logic [FIELD_W-1:0] stream_bytes_16_23;
   logic [FIELD_W-1:0] stream_bytes_24_31;
   logic [FIELD_W-1:0] stream_bytes_32_39;
   logic [FIELD_W-1:0] stream_bytes_40_47;
   logic [FIELD_W-1:0] stream_bytes_48_55;
   logic [FIELD_W-1:0] stream_bytes_56_63;

   modport source (output valid, input ready,
                   output stream_bytes_0_7, output stream_bytes_8_15,
                   output stream_bytes_16_23, output stream_bytes_24_31,
                   output stream_bytes_32_39, output stream_bytes_40_47,
                   output stream_bytes_48_55, output stream_bytes_56_63);
   modport sink   (input valid, output ready,
                   input stream_bytes_0_7, input stream_bytes_8_15,
                   input stream_bytes_16_23, input stream_bytes_24_31,
                   input stream_bytes_32_39, input stream_bytes_40_47,
                   input stream_bytes_48_55, input stream_bytes_56_63);
endinterface

interface cc20_csr_if
   import cc20_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [FIELD_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/cc20_qr_stage.sv
// One pipeline stage: a quarter-round step over all four quarter rounds of a round.
module cc20_qr_stage
   import cc20_pkg::*;
#(
   parameter int unsigned STEP = 0,
   parameter bit          DIAG = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  word_array_type       in_state,
   input  logic [COUNTER_W-1:0] in_counter,
   output logic                 out_valid,
   output word_array_type       out_state,
   output logic [COUNTER_W-1:0] out_counter
);

   logic                 valid_ff;
   word_array_type       state_ff, state_in;
   logic [COUNTER_W-1:0] counter_ff;

   assign state_in = qr_step(in_state, step_type'(2'(STEP)), DIAG);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff   <= state_in;
         counter_ff <= in_counter;
      end
   end

   assign out_valid   = valid_ff;
   assign out_state   = state_ff;
   assign out_counter = counter_ff;

endmodule

FILE: src/cc20_out_stage.sv
// Output register: adds the input state back in and holds the item until it is taken.
module cc20_out_stage
   import cc20_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  word_array_type  in_state,
   input  word_array_type  in_init,
   input  logic            out_ready,
   output logic            advance,
   output logic            out_valid,
   output field_array_type out_fields
);

   logic            valid_ff;
   field_array_type fields_ff, fields_in;
   word_array_type  sum;

   always_comb begin
      for (int i = 0; i < NUM_WORDS; i++) begin
         sum[i] = in_state[i] + in_init[i];
      end
      for (int k = 0; k < NUM_FIELDS; k++) begin
         fields_in[k] = {sum[2 * k + 1], sum[2 * k]};
      end
   end

   // The whole pipeline moves unless a finished item waits here unclaimed.
   assign advance = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fields_ff <= fields_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_fields = fields_ff;

endmodule

FILE: src/chacha20_keystream_block_top.sv
// Top level of the pipelined ChaCha20 keystream block generator.
// Usage: write the 256-bit key and the 96-bit nonce through csr_ch (index 0 to 3
// for the key, 4 and 5 for the nonce) while no item is in flight; writes to other
// indexes are ignored and csr_ch is always ready. Then send one 32-bit block
// counter per item on req_ch; the feeder advances the counter itself.
// Each item yields one item on rsp_ch with the 64 keystream bytes as eight
// little-endian 64-bit fields.
// Every quarter-round step (one add, one xor, one rotate on the four quarter
// rounds of a round) is a register stage, and the final stage adds the input
// state back in.
// Throughput is one item per clock cycle as long as the receiver takes items.
// When the receiver stalls while a result waits in the output register, the
// whole pipeline holds and req_ch.ready falls; no item is lost or repeated,
// and bubbles in flight keep moving toward the output otherwise.
// Reset clears all stage valid bits and the key and nonce registers to zero.
`include "chacha20_keystream_block_top_macros.svh"

module chacha20_keystream_block_top
   import cc20_pkg::*;
#(
   parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   cc20_req_if.sink   req_ch,
   cc20_rsp_if.source rsp_ch,
   cc20_csr_if.sink   csr_ch
);

   // An odd round count is rounded up to whole column/diagonal pairs.
   localparam int unsigned NUM_STEPS = ((ROUND_COUNT + 1) / 2) * 8;

   key_array_type      key_ff;
   logic [FIELD_W-1:0] nonce01_ff;
   logic [WORD_W-1:0]  nonce2_ff;

   logic                 advance;
   logic [NUM_STEPS:0]   stage_valid;
   word_array_type       stage_state   [NUM_STEPS+1];
   logic [COUNTER_W-1:0] stage_counter [NUM_STEPS+1];
   word_array_type       final_init;
   field_array_type      rsp_fields;

   // Configuration registers; the user must write them only while the block is idle, which it does not enforce.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         nonce01_ff <= '0;
         nonce2_ff  <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_KEY_01:   key_ff[0]  <= csr_ch.data;
            CSR_KEY_23:   key_ff[1]  <= csr_ch.data;
            CSR_KEY_45:   key_ff[2]  <= csr_ch.data;
            CSR_KEY_67:   key_ff[3]  <= csr_ch.data;
            CSR_NONCE_01: nonce01_ff <= csr_ch.data;
            CSR_NONCE_2:  nonce2_ff  <= csr_ch.data[WORD_W-1:0];
            default:      ;
         endcase
      end
   end

   // Stage zero input: the initial state is pure wiring of key, nonce and counter.
   assign req_ch.ready     = advance;
   assign stage_valid[0]   = req_ch.valid;
   assign stage_counter[0] = req_ch.block_counter;
   assign stage_state[0]   = init_state(key_ff, nonce01_ff, nonce2_ff, req_ch.block_counter);

   // Step k belongs to round k/4; even rounds work on columns, odd on diagonals.
   for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
      cc20_qr_stage #(
         .STEP (k % 4),
         .DIAG (1'((k / 4) % 2))
      ) u_stage (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .in_valid    (stage_valid[k]),
         .in_state    (stage_state[k]),
         .in_counter  (stage_counter[k]),
         .out_valid   (stage_valid[k+1]),
         .out_state   (stage_state[k+1]),
         .out_counter (stage_counter[k+1])
      );
   end

   // Only the counter travels with the item; the block trusts the user to keep key and nonce put while busy.
   assign final_init = init_state(key_ff, nonce01_ff, nonce2_ff, stage_counter[NUM_STEPS]);

   cc20_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (stage_valid[NUM_STEPS]),
      .in_state   (stage_state[NUM_STEPS]),
      .in_init    (final_init),
      .out_ready  (rsp_ch.ready),
      .advance    (advance),
      .out_valid  (rsp_ch.valid),
      .out_fields (rsp_fields)
   );

   assign rsp_ch.stream_bytes_0_7   = rsp_fields[0];
   assign rsp_ch.stream_bytes_8_15  = rsp_fields[1];
   assign rsp_ch.stream_bytes_16_23 = rsp_fields[2];
   assign rsp_ch.stream_bytes_24_31 = rsp_fields[3];
   assign rsp_ch.stream_bytes_32_39 = rsp_fields[4];
   assign rsp_ch.stream_bytes_40_47 = rsp_fields[5];
   assign rsp_ch.stream_bytes_48_55 = rsp_fields[6];
   assign rsp_ch.stream_bytes_56_63 = rsp_fields[7];

   // An accepted item must occupy the first stage in the next cycle.
   `CC20_ASSERT_NEXT(a_accept_enters, clock, reset, req_ch.valid && req_ch.ready, stage_valid[1], "accepted item did not enter the first stage")
   // While the output stalls, no stage may gain or drop an item.
   `CC20_ASSERT_NEXT(a_stall_holds, clock, reset, !advance, $stable(stage_valid[NUM_STEPS:1]), "pipeline valid bits moved during a stall")
   // An item leaving the last round stage must appear at the output.
   `CC20_ASSERT_NEXT(a_last_to_out, clock, reset, advance && stage_valid[NUM_STEPS], rsp_ch.valid, "item from the last stage did not reach the output")

endmodule

FILE: tb/sv/chacha20_keystream_block_top_tb.sv
// Self-checking testbench of the ChaCha20 keystream block: known-answer table, then random phases.
module chacha20_keystream_block_top_tb
   import cc20_pkg::*;
();

   // The block is built with its default round count. The predictor works for any
   // count, and rounds an odd one up to whole double rounds just as the block does.
   localparam int unsigned ROUNDS         = ROUND_COUNT_DEFAULT;
   localparam int unsigned DOUBLE_ROUNDS  = (ROUNDS + 1) / 2;
   localparam int unsigned LATENCY        = 8 * DOUBLE_ROUNDS + 1;
   localparam int unsigned CLOCK_PERIOD   = 8;
   localparam int unsigned RESET_CYCLES   = 8;
   localparam int unsigned HOLD_CYCLES    = 250;
   localparam int unsigned PHASES         = 8;
   localparam int unsigned PHASE_ITEMS    = 130;
   localparam int unsigned TIMEOUT_CYCLES = 400000;

   // Indexes past the last register. Writes to them must leave the key and nonce alone.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_7 = 3'd7;

   localparam logic [FIELD_W-1:0] ALL_ONES = {FIELD_W{1'b1}};

   // Keystream of the all-zero key and nonce at counter 0, which is also the state
   // right after reset. Field 0 is the last value in each concatenation.
   localparam field_array_type ZERO_KEY_BLOCK = {
      64'h8665eeb2_69b687c3, 64'h1ca11815_f4b8436a,
      64'h374ad8b8_3fe02477, 64'h8d485751_7c5941da,
      64'hc70d778b_ccef36a8, 64'h1aed8da0_b819d2bd,
      64'h28bd8653_e56a5d40, 64'h903df1a0_ade0b876
   };

   // Published block-function vector: key bytes 00..1f, nonce 00 00 00 09 00 00 00 4a
   // 00 00 00 00, counter 1.
   localparam logic [FIELD_W-1:0] VEC_KEY_01   = 64'h07060504_03020100;
   localparam logic [FIELD_W-1:0] VEC_KEY_23   = 64'h0f0e0d0c_0b0a0908;
   localparam logic [FIELD_W-1:0] VEC_KEY_45   = 64'h17161514_13121110;
   localparam logic [FIELD_W-1:0] VEC_KEY_67   = 64'h1f1e1d1c_1b1a1918;
   localparam logic [FIELD_W-1:0] VEC_NONCE_01 = 64'h4a000000_09000000;
   localparam field_array_type VEC_BLOCK = {
      64'h4e3c50a2_e883d0cb, 64'hb94e16de_d19c12b5,
      64'ha2028bd9_05d7c214, 64'h09aa9f07_466482d2,
      64'h4e6cd4c3_9aaa2204, 64'h0368c033_c7f4d1c7,
      64'hc47120a3_1fdd0f50, 64'h15593bd1_e4e7f110
   };

   // One row of the directed table: a register write, a counter checked against the
   // predictor, or a counter whose keystream is a known answer.
   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_BLOCK,
      ROW_KNOWN
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [FIELD_W-1:0]     data;
      logic [COUNTER_W-1:0]   counter;
      field_array_type        known;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cc20_req_if req_ch ();
   cc20_rsp_if rsp_ch ();
   cc20_csr_if csr_ch ();

   chacha20_keystream_block_top #(
      .ROUND_COUNT(ROUNDS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // The testbench's own copy of the key and nonce registers.
   key_array_type      cfg_key;
   logic [FIELD_W-1:0] cfg_nonce01;
   logic [WORD_W-1:0]  cfg_nonce2;

   // Keystream blocks still owed by the block, oldest first.
   field_array_type expected_blocks[$];

   int unsigned error_count  = 0;
   int unsigned result_count = 0;

   // Idling modes: a burst side never idles, and the hold makes the receiver refuse
   // results long enough for the whole pipeline to fill and stall the input.
   bit req_burst   = 1'b0;
   bit rsp_burst   = 1'b0;
   bit hold_output = 1'b0;

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // One ChaCha quarter round on words a, b, c and d.
   function automatic word_array_type quarter_round(input word_array_type w,
                                                    input int a, input int b,
                                                    input int c, input int d);
      w[a] = w[a] + w[b];
      w[d] = w[d] ^ w[a];
      w[d] = {w[d][15:0], w[d][31:16]};
      w[c] = w[c] + w[d];
      w[b] = w[b] ^ w[c];
      w[b] = {w[b][19:0], w[b][31:20]};
      w[a] = w[a] + w[b];
      w[d] = w[d] ^ w[a];
      w[d] = {w[d][23:0], w[d][31:24]};
      w[c] = w[c] + w[d];
      w[b] = w[b] ^ w[c];
      w[b] = {w[b][24:0], w[b][31:25]};
      return w;
   endfunction

   // Expected keystream block for one counter under the current key and nonce.
   function automatic field_array_type keystream_block(input logic [COUNTER_W-1:0] counter);
      word_array_type  start_state;
      word_array_type  mixed;
      field_array_type stream;
      start_state[0] = SIGMA0;
      start_state[1] = SIGMA1;
      start_state[2] = SIGMA2;
      start_state[3] = SIGMA3;
      for (int i = 0; i < NUM_KEY_REGS; i++) begin
         start_state[4 + 2 * i] = cfg_key[i][WORD_W-1:0];
         start_state[5 + 2 * i] = cfg_key[i][FIELD_W-1:WORD_W];
      end
      start_state[12] = counter;
      start_state[13] = cfg_nonce01[WORD_W-1:0];
      start_state[14] = cfg_nonce01[FIELD_W-1:WORD_W];
      start_state[15] = cfg_nonce2;
      mixed = start_state;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
         // Column round, then diagonal round.
         mixed = quarter_round(mixed, 0, 4, 8, 12);
         mixed = quarter_round(mixed, 1, 5, 9, 13);
         mixed = quarter_round(mixed, 2, 6, 10, 14);
         mixed = quarter_round(mixed, 3, 7, 11, 15);
         mixed = quarter_round(mixed, 0, 5, 10, 15);
         mixed = quarter_round(mixed, 1, 6, 11, 12);
         mixed = quarter_round(mixed, 2, 7, 8, 13);
         mixed = quarter_round(mixed, 3, 4, 9, 14);
      end
      for (int i = 0; i < NUM_WORDS; i++)
         mixed[i] = mixed[i] + start_state[i];
      for (int k = 0; k < NUM_FIELDS; k++)
         stream[k] = {mixed[2 * k + 1], mixed[2 * k]};
      return stream;
   endfunction

   function automatic row_type row_write(input logic [CSR_INDEX_W-1:0] reg_index,
                                         input logic [FIELD_W-1:0] data);
      row_type row;
      row           = '0;
      row.kind      = ROW_WRITE;
      row.reg_index = reg_index;
      row.data      = data;
      return row;
   endfunction

   function automatic row_type row_block(input logic [COUNTER_W-1:0] counter);
      row_type row;
      row         = '0;
      row.kind    = ROW_BLOCK;
      row.counter = counter;
      return row;
   endfunction

   function automatic row_type row_known(input logic [COUNTER_W-1:0] counter,
                                         input field_array_type known);
      row_type row;
      row         = '0;
      row.kind    = ROW_KNOWN;
      row.counter = counter;
      row.known   = known;
      return row;
   endfunction

   // Gap before an item, in cycles: mostly none or short, now and then long.
   function automatic int unsigned pick_gap(input bit burst);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (burst || roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string line);
      $display("%0t ERROR: %s", $time, line);
      error_count++;
   endtask

   // Lowers the request valid and waits until every owed block has come back, so
   // that the registers can be rewritten. Called and returns at a falling edge.
   task automatic wait_idle();
      req_ch.valid = 1'b0;
      while (expected_blocks.size() != 0)
         @(negedge clock);
   endtask

   // One register write. The local copy follows the block: unused indexes change
   // nothing, and the third nonce word keeps only its low 32 bits.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] reg_index,
                                 input logic [FIELD_W-1:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.index = reg_index;
      csr_ch.data  = data;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      case (csr_index_type'(reg_index))
         CSR_KEY_01:   cfg_key[0]  = data;
         CSR_KEY_23:   cfg_key[1]  = data;
         CSR_KEY_45:   cfg_key[2]  = data;
         CSR_KEY_67:   cfg_key[3]  = data;
         CSR_NONCE_01: cfg_nonce01 = data;
         CSR_NONCE_2:  cfg_nonce2  = data[WORD_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Offers one counter after a random gap and books its keystream once the item
   // is taken. Valid stays high afterwards, so back-to-back items need no toggle.
   task automatic send_counter(input logic [COUNTER_W-1:0] counter, input bit use_known,
                               input field_array_type known);
      int unsigned gap;
      gap = pick_gap(req_burst);
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         = 1'b1;
      req_ch.block_counter = counter;
      do
         @(posedge clock);
      while (!req_ch.ready);
      if (use_known)
         expected_blocks.push_back(known);
      else
         expected_blocks.push_back(keystream_block(counter));
      @(negedge clock);
   endtask

   // Receiver: random gaps in ready, or none in a burst phase. When a hold is asked
   // for, ready stays low through a hold counted here, while the sender keeps
   // offering items; the pipeline fills and the input stalls.
   initial begin
      int unsigned gap;
      rsp_ch.ready = 1'b0;
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_output) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_output = 1'b0;
         end
         gap = pick_gap(rsp_burst);
         if (gap != 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do
            @(posedge clock);
         while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // Every accepted result is compared field by field with the oldest owed block.
   always @(posedge clock) begin : result_check
      field_array_type got;
      field_array_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.stream_bytes_56_63, rsp_ch.stream_bytes_48_55,
                rsp_ch.stream_bytes_40_47, rsp_ch.stream_bytes_32_39,
                rsp_ch.stream_bytes_24_31, rsp_ch.stream_bytes_16_23,
                rsp_ch.stream_bytes_8_15,  rsp_ch.stream_bytes_0_7};
         if (expected_blocks.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      result_count));
         end else begin
            want = expected_blocks.pop_front();
            for (int k = 0; k < NUM_FIELDS; k++)
               if (got[k] !== want[k])
                  report_mismatch($sformatf("result %0d field %0d: got %h expected %h",
                                            result_count, k, got[k], want[k]));
         end
         result_count++;
      end
   end

   // Stimulus: reset, the directed table, then the random phases.
   initial begin
      row_type              rows[$];
      logic [COUNTER_W-1:0] next_counter;
      logic [COUNTER_W-1:0] counter;
      logic [FIELD_W-1:0]   setting;
      int unsigned          p;
      int unsigned          n;
      int                   i;

      req_ch.valid         = 1'b0;
      req_ch.block_counter = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = '0;
      csr_ch.data          = '0;
      cfg_key              = '0;
      cfg_nonce01          = '0;
      cfg_nonce2           = '0;

      // Reset is held once, at the start of the run.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Straight out of reset the key and nonce are zero, so counter 0 must give
      // the well-known all-zero keystream. Counter extremes follow.
      rows.push_back(row_known(32'h0000_0000, ZERO_KEY_BLOCK));
      rows.push_back(row_block(32'hffff_ffff));
      rows.push_back(row_block(32'h8000_0000));

      // Load the published vector and check its known answer, then the extremes.
      rows.push_back(row_write(CSR_KEY_01, VEC_KEY_01));
      rows.push_back(row_write(CSR_KEY_23, VEC_KEY_23));
      rows.push_back(row_write(CSR_KEY_45, VEC_KEY_45));
      rows.push_back(row_write(CSR_KEY_67, VEC_KEY_67));
      rows.push_back(row_write(CSR_NONCE_01, VEC_NONCE_01));
      rows.push_back(row_write(CSR_NONCE_2, '0));
      rows.push_back(row_known(32'h0000_0001, VEC_BLOCK));
      rows.push_back(row_block(32'h0000_0000));
      rows.push_back(row_block(32'hffff_ffff));

      // Writes to the indexes past the last register are ignored, so the known
      // answer must still hold afterwards.
      rows.push_back(row_write(CSR_UNUSED_6, ALL_ONES));
      rows.push_back(row_write(CSR_UNUSED_7, ALL_ONES));
      rows.push_back(row_known(32'h0000_0001, VEC_BLOCK));

      // The third nonce word is 32 bits wide: the upper half of the write is dropped.
      rows.push_back(row_write(CSR_NONCE_2, ALL_ONES));
      rows.push_back(row_block(32'h0000_0001));

      // Every register at all ones, counters around the wrap and in patterns.
      for (i = CSR_KEY_01; i <= CSR_NONCE_2; i++)
         rows.push_back(row_write(CSR_INDEX_W'(i), ALL_ONES));
      rows.push_back(row_block(32'h0000_0000));
      rows.push_back(row_block(32'hffff_ffff));
      rows.push_back(row_block(32'h0000_0000));
      rows.push_back(row_block(32'h5a5a_5a5a));
      rows.push_back(row_block(32'ha5a5_a5a5));

      // Back to all zeros: the reset keystream must come back exactly.
      for (i = CSR_KEY_01; i <= CSR_NONCE_2; i++)
         rows.push_back(row_write(CSR_INDEX_W'(i), '0));
      rows.push_back(row_known(32'h0000_0000, ZERO_KEY_BLOCK));

      // Register writes only happen once every owed block is back. The known
      // answers belong to the standard round count; otherwise the predictor rules.
      foreach (rows[r]) begin
         if (rows[r].kind == ROW_WRITE) begin
            wait_idle();
            write_register(rows[r].reg_index, rows[r].data);
         end else
            send_counter(rows[r].counter, rows[r].kind == ROW_KNOWN && ROUNDS == 20,
                         rows[r].known);
      end

      // Random phases. Each waits for the block to drain, loads a new key and nonce
      // (extremes in some phases), and then feeds a mostly consecutive counter
      // stream the way a real feeder does, with some random jumps. Odd phases start
      // just below the top so that the counter wraps. Phase 2 runs with no idling on
      // either side; phase 5 bursts into a long output hold.
      for (p = 0; p < PHASES; p++) begin
         wait_idle();
         req_burst = (p == 2) || (p == 5);
         rsp_burst = (p == 2) || (p == 6);
         for (i = CSR_KEY_01; i <= CSR_NONCE_2; i++) begin
            case (p)
               0:       setting = ALL_ONES;
               2:       setting = 64'd1 << $urandom_range(0, FIELD_W - 1);
               4:       setting = '0;
               7:       setting = $urandom_range(0, 1) ? 64'haaaa_aaaa_aaaa_aaaa
                                                       : 64'h5555_5555_5555_5555;
               default: setting = {$urandom(), $urandom()};
            endcase
            write_register(CSR_INDEX_W'(i), setting);
         end
         if ($urandom_range(0, 1))
            write_register($urandom_range(0, 1) ? CSR_UNUSED_6 : CSR_UNUSED_7,
                           {$urandom(), $urandom()});
         next_counter = (p % 2 == 1) ? 32'hffff_ffff - $urandom_range(0, 40) : $urandom();
         hold_output  = (p == 5);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (p != 2 && p != 5 && n % 32 == 0)
               req_burst = ($urandom_range(0, 3) == 0);
            counter = ($urandom_range(0, 99) < 15) ? $urandom() : next_counter;
            send_counter(counter, 1'b0, '0);
            next_counter = counter + 1;
         end
      end

      // Drain, then let the pipeline run empty so that any stray result shows.
      wait_idle();
      repeat (LATENCY) @(negedge clock);
      if (error_count == 0)
         $display("chacha20_keystream_block_top_tb passed");
      else
         $display("chacha20_keystream_block_top_tb failed");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("chacha20_keystream_block_top_tb failed");
      $finish;
   end

endmodule
